// File: hdl/sled_pkg.sv
// ----------------------------------------------------------------------------
// sled_pkg
// Shared types and constants of the string literal escape decoder.
// ----------------------------------------------------------------------------
package sled_pkg;

  // error codes carried in tuser
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_EOF        = 3'd1;
  localparam logic [2:0] ERR_NEWLINE    = 3'd2;
  localparam logic [2:0] ERR_BAD_ESC    = 3'd3;
  localparam logic [2:0] ERR_BOLD_QUOTE = 3'd4;

  // result queue depth: two entries for one item plus slack for back-to-back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // one result item
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [2:0] err;
  } res_t;

  // results produced by one input item
  typedef struct packed {
    logic vld0;
    logic vld1;
    res_t res0;
    res_t res1;
  } res_pair_t;

endpackage

// File: hdl/sled_decode.sv
// ----------------------------------------------------------------------------
// sled_decode
// Escape decoder state and next-state logic; yields up to two results per char.
// ----------------------------------------------------------------------------
module sled_decode
  import sled_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,      // char transfer this cycle
  input  logic [7:0] char_in,
  output res_pair_t  res        // valid only while take is high
);

  localparam logic [2:0] PH_AWAIT  = 3'd0;
  localparam logic [2:0] PH_STRING = 3'd1;
  localparam logic [2:0] PH_ESCAPE = 3'd2;
  localparam logic [2:0] PH_OCTAL  = 3'd3;
  localparam logic [2:0] PH_HEX    = 3'd4;
  localparam logic [2:0] PH_CARET  = 3'd5;

  localparam logic [7:0] HIGH_BIT = 8'h80;
  localparam logic [7:0] C_NUL    = 8'h00;
  localparam logic [7:0] C_NL     = 8'h0A;
  localparam logic [7:0] C_QUOTE  = 8'h22;
  localparam logic [7:0] C_BSL    = 8'h5C;
  localparam logic [7:0] C_CARET  = 8'h5E;
  localparam logic [7:0] C_LT     = 8'h3C;
  localparam logic [7:0] C_GT     = 8'h3E;
  localparam logic [7:0] C_X      = 8'h78;
  localparam logic [7:0] ESC_BYTE = 8'h1B;

  typedef struct packed {
    logic [2:0] ph;
    logic       vld;
    res_t       res;
    logic       bold;
  } plain_t;

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic [1:0] oct_r, oct_nxt;
  logic       mask_r, mask_nxt;
  logic       bold_r, bold_nxt;

  function automatic res_t byte_res(logic [7:0] c, logic bold, logic mask);
    res_t r;
    r.data = c ^ (bold ? HIGH_BIT : 8'h00) ^ (mask ? HIGH_BIT : 8'h00);
    r.last = 1'b0;
    r.err  = ERR_NONE;
    return r;
  endfunction

  function automatic res_t err_res(logic [2:0] code);
    res_t r;
    r.data = 8'h00;
    r.last = 1'b0;
    r.err  = code;
    return r;
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) v = c - 8'h30;
    else if (c <= 8'h46) v = c - 8'h37;
    else v = c - 8'h57;
    return v[3:0];
  endfunction

  // ordinary character inside the literal
  function automatic plain_t plain(logic [7:0] c, logic bold, logic mask);
    plain_t p;
    p.ph   = PH_STRING;
    p.vld  = 1'b1;
    p.res  = byte_res(c, bold, mask);
    p.bold = bold;
    priority if (c == C_NUL) begin
      p.res = err_res(ERR_EOF);
      p.ph  = PH_AWAIT;
    end else if (c == C_NL) begin
      p.res = err_res(ERR_NEWLINE);
      p.ph  = PH_AWAIT;
    end else if (c == C_BSL) begin
      p.vld = 1'b0;
      p.ph  = PH_ESCAPE;
    end else if (c == C_QUOTE) begin
      p.res      = err_res(ERR_NONE);
      p.res.last = 1'b1;
      p.ph       = PH_AWAIT;
    end else begin
      p.bold = 1'b0;
    end
    return p;
  endfunction

  plain_t     pl_c;   // char as plain, current bold
  plain_t     pl_t;   // char as plain after a numeric escape (bold consumed)
  logic [7:0] oct_acc;

  always_comb begin
    pl_c    = plain(char_in, bold_r, mask_r);
    pl_t    = plain(char_in, 1'b0, mask_r);
    oct_acc = {acc_r[4:0], char_in[2:0]};

    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    oct_nxt   = oct_r;
    mask_nxt  = mask_r;
    bold_nxt  = bold_r;
    res.vld0  = 1'b0;
    res.vld1  = 1'b0;
    res.res0  = err_res(ERR_NONE);
    res.res1  = err_res(ERR_NONE);

    unique case (phase_r)
      PH_AWAIT: begin
        // opening quote: skipped whatever it is
        mask_nxt  = 1'b0;
        bold_nxt  = 1'b0;
        acc_nxt   = 8'h00;
        oct_nxt   = 2'd0;
        phase_nxt = PH_STRING;
      end
      PH_ESCAPE: begin
        phase_nxt = PH_STRING;
        res.vld0  = 1'b1;
        bold_nxt  = 1'b0;
        unique case (char_in)
          C_NUL: begin
            res.res0  = err_res(ERR_EOF);
            bold_nxt  = bold_r;
            phase_nxt = PH_AWAIT;
          end
          8'h6E:   res.res0 = byte_res(C_NL, bold_r, mask_r);
          C_QUOTE: res.res0 = byte_res(C_QUOTE, bold_r, mask_r);
          8'h61:   res.res0 = byte_res(8'h07, bold_r, mask_r);
          8'h62:   res.res0 = byte_res(8'h08, bold_r, mask_r);
          8'h65:   res.res0 = byte_res(ESC_BYTE, bold_r, mask_r);
          8'h66:   res.res0 = byte_res(8'h0C, bold_r, mask_r);
          8'h72:   res.res0 = byte_res(8'h0D, bold_r, mask_r);
          8'h74:   res.res0 = byte_res(8'h09, bold_r, mask_r);
          8'h76:   res.res0 = byte_res(8'h0B, bold_r, mask_r);
          C_X: begin
            res.vld0  = 1'b0;
            bold_nxt  = bold_r;
            acc_nxt   = 8'h00;
            phase_nxt = PH_HEX;
          end
          C_CARET: begin
            res.vld0  = 1'b0;
            bold_nxt  = 1'b1;
            phase_nxt = PH_CARET;
          end
          C_LT: begin
            res.vld0 = 1'b0;
            bold_nxt = bold_r;
            mask_nxt = 1'b1;
          end
          C_GT: begin
            res.vld0 = 1'b0;
            bold_nxt = bold_r;
            mask_nxt = 1'b0;
          end
          default: begin
            bold_nxt = bold_r;
            if (char_in >= 8'h30 && char_in <= 8'h37) begin
              res.vld0  = 1'b0;
              acc_nxt   = {5'd0, char_in[2:0]};
              oct_nxt   = 2'd1;
              phase_nxt = PH_OCTAL;
            end else begin
              res.res0  = err_res(ERR_BAD_ESC);
              phase_nxt = PH_AWAIT;
            end
          end
        endcase
      end
      PH_OCTAL: begin
        res.vld0 = 1'b1;
        if (char_in >= 8'h30 && char_in <= 8'h37 && oct_r != 2'd3) begin
          acc_nxt = oct_acc;
          if (oct_r == 2'd2) begin
            // third digit closes the escape
            oct_nxt   = 2'd0;
            phase_nxt = PH_STRING;
            res.res0  = byte_res(oct_acc, bold_r, mask_r);
            bold_nxt  = 1'b0;
          end else begin
            oct_nxt  = oct_r + 2'd1;
            res.vld0 = 1'b0;
          end
        end else begin
          // terminator: numeric byte, then char as ordinary
          oct_nxt   = 2'd0;
          res.res0  = byte_res(acc_r, bold_r, mask_r);
          res.vld1  = pl_t.vld;
          res.res1  = pl_t.res;
          bold_nxt  = 1'b0;
          phase_nxt = pl_t.ph;
        end
      end
      PH_HEX: begin
        if (is_hex(char_in)) begin
          acc_nxt = {acc_r[3:0], hex_val(char_in)};
        end else begin
          res.vld0  = 1'b1;
          res.res0  = byte_res(acc_r, bold_r, mask_r);
          res.vld1  = pl_t.vld;
          res.res1  = pl_t.res;
          bold_nxt  = 1'b0;
          phase_nxt = pl_t.ph;
        end
      end
      PH_CARET: begin
        if (char_in == C_QUOTE) begin
          res.vld0  = 1'b1;
          res.res0  = err_res(ERR_BOLD_QUOTE);
          phase_nxt = PH_AWAIT;
        end else begin
          res.vld0  = pl_c.vld;
          res.res0  = pl_c.res;
          bold_nxt  = pl_c.bold;
          phase_nxt = pl_c.ph;
        end
      end
      default: begin
        // PH_STRING and unused codes
        res.vld0  = pl_c.vld;
        res.res0  = pl_c.res;
        bold_nxt  = pl_c.bold;
        phase_nxt = pl_c.ph;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_AWAIT;
      acc_r   <= 8'h00;
      oct_r   <= 2'd0;
      mask_r  <= 1'b0;
      bold_r  <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      oct_r   <= oct_nxt;
      mask_r  <= mask_nxt;
      bold_r  <= bold_nxt;
    end
  end

endmodule

// File: hdl/sled_resq.sv
// ----------------------------------------------------------------------------
// sled_resq
// Small result queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module sled_resq
  import sled_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  res_pair_t din,
  output logic      room2,      // at least two free entries
  output logic      out_valid,
  input  logic      out_ready,
  output res_t      dout
);

  res_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;
  logic              w0, w1;
  res_t              wd0, wd1;
  logic [QPTR_W-1:0] wa1;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign dout      = mem_r[rd_ptr_r];
  assign room2     = (cnt_r <= QCNT_W'(QDEPTH - 2));

  // pack the pair so that a lone result always lands first
  always_comb begin
    w0  = push && (din.vld0 || din.vld1);
    w1  = push && din.vld0 && din.vld1;
    wd0 = din.vld0 ? din.res0 : din.res1;
    wd1 = din.res1;
    wa1 = wr_ptr_r + QPTR_W'(1);
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(w0) + QPTR_W'(w1);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    cnt_nxt    = cnt_r + QCNT_W'(w0) + QCNT_W'(w1) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (w0) mem_r[wr_ptr_r] <= wd0;
    if (w1) mem_r[wa1]      <= wd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: hdl/string_literal_escape_decoder_unit.sv
// ----------------------------------------------------------------------------
// string_literal_escape_decoder_unit
// Streams source characters in, decoded string bytes, end and error marks out.
// ----------------------------------------------------------------------------
// Output: each result is written to the result queue at the transfer.
// Throughput: one character per cycle while the queue has room for two results;
//   a character that ends a numeric escape can give two results, which drain
//   in order through the 4-entry result queue, whose fill level sets in_tready.
// Reset: rst_n synchronous, active low; decoder awaits an opening quote and
//   the result queue is empty.
// ----------------------------------------------------------------------------
module string_literal_escape_decoder_unit
  import sled_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // source characters
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_in
  // decoded results
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // end_of_string
  output logic [2:0] out_tuser   // [2:0] error_code
);

  logic      take;
  logic      room2;
  res_pair_t pair;
  res_t      head;

  // A character is taken only while the queue can absorb both possible
  // results, so no result is ever dropped.
  assign in_tready = room2;
  assign take      = in_tvalid && in_tready;

  // Decoder: state registers plus one pass of escape logic per transfer.
  sled_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .char_in (in_tdata),
    .res     (pair)
  );

  // Result queue parts the input side from output stalls.
  sled_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .din       (pair),
    .room2     (room2),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .dout      (head)
  );

  assign out_tdata = head.data;
  assign out_tlast = head.last;
  assign out_tuser = head.err;

endmodule
